### rtl/nat_flow_rewriter_assert.svh
// Assertion macros for the flow rewriter.
`ifndef NAT_FLOW_REWRITER_ASSERT_SVH
`define NAT_FLOW_REWRITER_ASSERT_SVH

`define NFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define NFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/nfr_pkg.sv
`default_nettype none
package nfr_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [15:0] MinTransport = 16'd8;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] REG_INPUT_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PAT_SRC_ADDR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PAT_SRC_PORT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PAT_DST_ADDR = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PAT_DST_PORT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VAR_TOP = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_VAR_TARGET = 3'd6;

  localparam logic [1:0] VERDICT_DROP = 2'd0;
  localparam logic [1:0] VERDICT_REWRITE = 2'd1;
  localparam logic [1:0] VERDICT_FULL = 2'd2;

  localparam logic [1:0] VAR_SRC_PORT = 2'd1;
  localparam logic [1:0] VAR_DST_ADDR = 2'd2;

  typedef struct packed {
    logic [7:0]  ip_protocol;
    logic [12:0] fragment_offset;
    logic [15:0] l4_len;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] old_checksum;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        was_match;
    logic [31:0] out_src_addr;
    logic [31:0] out_dst_addr;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [15:0] new_checksum;
  } out_item_t;

  typedef struct packed {
    logic        input_mode;
    logic [31:0] pat_src_addr;
    logic [15:0] pat_src_port;
    logic [31:0] pat_dst_addr;
    logic [15:0] pat_dst_port;
    logic [31:0] var_top;
    logic [1:0]  var_target;
  } cfg_t;

  // queue entry between front and back
  typedef struct packed {
    logic     eligible;
    in_item_t hdr;
  } cls_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_REV,
    ST_DECIDE,
    ST_EMIT
  } back_st_t;

  function automatic logic [15:0] csum_update(input logic [15:0] hc,
      input logic [31:0] os, input logic [31:0] od,
      input logic [31:0] ns, input logic [31:0] nd);
    logic [19:0] s;
    s = {4'd0, ~hc} + {4'd0, ~os[31:16]} + {4'd0, ns[31:16]}
      + {4'd0, ~os[15:0]} + {4'd0, ns[15:0]}
      + {4'd0, ~od[31:16]} + {4'd0, nd[31:16]}
      + {4'd0, ~od[15:0]} + {4'd0, nd[15:0]};
    s = {4'd0, s[15:0]} + {16'd0, s[19:16]};
    s = {4'd0, s[15:0]} + {16'd0, s[19:16]};
    return ~s[15:0];
  endfunction

endpackage
`default_nettype wire

### rtl/nfr_front.sv
`default_nettype none
module nfr_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire nfr_pkg::in_item_t   hdr,
  output nfr_pkg::cls_item_t       cls_r
);
  nfr_pkg::cls_item_t cls_nxt;

  always_comb begin
    cls_nxt.hdr = hdr;
    cls_nxt.eligible = (hdr.ip_protocol == nfr_pkg::ProtoTcp
                        || hdr.ip_protocol == nfr_pkg::ProtoUdp)
                       && hdr.fragment_offset == 13'd0
                       && hdr.l4_len >= nfr_pkg::MinTransport;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= '0;
    end else if (take) begin
      cls_r <= cls_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/nfr_queue.sv
`default_nettype none
module nfr_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire nfr_pkg::cls_item_t wdata,
  input  wire logic               pop,
  output nfr_pkg::cls_item_t      rdata,
  output logic                    full,
  output logic                    empty
);
  localparam int unsigned Depth = nfr_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(Depth);

  nfr_pkg::cls_item_t mem [Depth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0] cnt_r;

  assign full = (cnt_r == Depth[PtrW:0]);
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{PtrW{1'b0}}, push && !full} - {{PtrW{1'b0}}, pop && !empty};
    end
  end
endmodule
`default_nettype wire

### rtl/nfr_back.sv
`default_nettype none
module nfr_back #(
  parameter int unsigned TABLE_ENTRIES = nfr_pkg::TableEntriesDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire nfr_pkg::cfg_t      cfg,
  input  wire logic               q_empty,
  input  wire nfr_pkg::cls_item_t q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  output nfr_pkg::out_item_t      out_item,
  output logic                    idle
);
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [63:0] key_a [TABLE_ENTRIES];
  logic [31:0] key_p [TABLE_ENTRIES];
  logic [63:0] rw_a [TABLE_ENTRIES];
  logic [31:0] rw_p [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  nfr_pkg::back_st_t st_r, st_nxt;
  nfr_pkg::in_item_t h_r;
  logic [31:0] off_r, off_nxt;
  logic [31:0] rsa_r, rda_r;
  logic [15:0] rsp_r, rdp_r;
  logic        rhit_r, same_r;
  logic [IdxW-1:0] ridx_r;
  nfr_pkg::out_item_t res_r, res_nxt;
  logic        ov_r, ov_nxt;

  // associative match and free-slot search over CAM flops
  logic [63:0] ska;
  logic [31:0] skp;
  logic        s_hit;
  logic [IdxW-1:0] s_idx;
  logic        f1_ok, f2_ok;
  logic [IdxW-1:0] f1_idx, f2_idx;

  always_comb begin
    s_hit = 1'b0;
    s_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_a[i] == ska && key_p[i] == skp) begin
        s_hit = 1'b1;
        s_idx = i[IdxW-1:0];
      end
    end
    f1_ok = 1'b0;
    f1_idx = '0;
    f2_ok = 1'b0;
    f2_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        f2_ok = f1_ok;
        f2_idx = f1_idx;
        f1_ok = 1'b1;
        f1_idx = i[IdxW-1:0];
      end
    end
  end

  logic [31:0] c_rsa, c_rda, c_val;
  logic [15:0] c_rsp, c_rdp;

  always_comb begin
    c_val = (off_r > cfg.var_top) ? 32'd0 : off_r;
    c_rsa = (cfg.pat_src_addr != '0) ? cfg.pat_src_addr : h_r.src_addr;
    c_rsp = (cfg.pat_src_port != '0) ? cfg.pat_src_port : h_r.src_port;
    c_rda = (cfg.pat_dst_addr != '0) ? cfg.pat_dst_addr : h_r.dst_addr;
    c_rdp = (cfg.pat_dst_port != '0) ? cfg.pat_dst_port : h_r.dst_port;
    if (cfg.var_target == nfr_pkg::VAR_SRC_PORT) begin
      c_rsp = cfg.pat_src_port + c_val[15:0];
    end else if (cfg.var_target == nfr_pkg::VAR_DST_ADDR) begin
      c_rda = cfg.pat_dst_addr + c_val;
    end
  end

  logic do_write;

  always_comb begin
    st_nxt = st_r;
    off_nxt = off_r;
    res_nxt = res_r;
    ov_nxt = 1'b0;
    q_pop = 1'b0;
    do_write = 1'b0;
    ska = {h_r.src_addr, h_r.dst_addr};
    skp = {h_r.src_port, h_r.dst_port};
    unique case (st_r)
      nfr_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.eligible) begin
            st_nxt = nfr_pkg::ST_FWD;
          end else begin
            res_nxt = '0;
            ov_nxt = 1'b1;
          end
        end
      end
      nfr_pkg::ST_FWD: begin
        if (s_hit) begin
          res_nxt.verdict = nfr_pkg::VERDICT_REWRITE;
          res_nxt.was_match = 1'b1;
          st_nxt = nfr_pkg::ST_EMIT;
        end else if (!cfg.input_mode) begin
          res_nxt = '0;
          ov_nxt = 1'b1;
          st_nxt = nfr_pkg::ST_IDLE;
        end else begin
          off_nxt = c_val + 32'd1;
          st_nxt = nfr_pkg::ST_REV;
        end
      end
      nfr_pkg::ST_REV: begin
        ska = {rda_r, rsa_r};
        skp = {rdp_r, rsp_r};
        st_nxt = nfr_pkg::ST_DECIDE;
      end
      nfr_pkg::ST_DECIDE: begin
        res_nxt.was_match = 1'b0;
        if (!f1_ok || (!same_r && !rhit_r && !f2_ok)) begin
          res_nxt.verdict = nfr_pkg::VERDICT_FULL;
          res_nxt.out_src_addr = h_r.src_addr;
          res_nxt.out_dst_addr = h_r.dst_addr;
          res_nxt.out_src_port = h_r.src_port;
          res_nxt.out_dst_port = h_r.dst_port;
          res_nxt.new_checksum = h_r.old_checksum;
          ov_nxt = 1'b1;
          st_nxt = nfr_pkg::ST_IDLE;
        end else begin
          do_write = 1'b1;
          res_nxt.verdict = nfr_pkg::VERDICT_REWRITE;
          st_nxt = nfr_pkg::ST_EMIT;
        end
      end
      nfr_pkg::ST_EMIT: begin
        res_nxt.out_src_addr = rsa_r;
        res_nxt.out_dst_addr = rda_r;
        res_nxt.out_src_port = rsp_r;
        res_nxt.out_dst_port = rdp_r;
        res_nxt.new_checksum = nfr_pkg::csum_update(h_r.old_checksum, h_r.src_addr,
            h_r.dst_addr, rsa_r, rda_r);
        ov_nxt = 1'b1;
        st_nxt = nfr_pkg::ST_IDLE;
      end
      default: st_nxt = nfr_pkg::ST_IDLE;
    endcase
  end

  logic [IdxW-1:0] rev_slot;
  assign rev_slot = same_r ? f1_idx : (rhit_r ? ridx_r : f2_idx);

  always_ff @(posedge clk) begin
    if (q_pop) h_r <= q_item.hdr;
    if (st_r == nfr_pkg::ST_FWD) begin
      if (s_hit) begin
        {rsa_r, rda_r} <= rw_a[s_idx];
        {rsp_r, rdp_r} <= rw_p[s_idx];
      end else begin
        rsa_r <= c_rsa;
        rda_r <= c_rda;
        rsp_r <= c_rsp;
        rdp_r <= c_rdp;
      end
    end
    if (st_r == nfr_pkg::ST_REV) begin
      rhit_r <= s_hit;
      ridx_r <= s_idx;
      same_r <= ({rda_r, rsa_r} == {h_r.src_addr, h_r.dst_addr})
             && ({rdp_r, rsp_r} == {h_r.src_port, h_r.dst_port});
    end
    if (do_write) begin
      key_a[rev_slot] <= {rda_r, rsa_r};
      key_p[rev_slot] <= {rdp_r, rsp_r};
      rw_a[rev_slot] <= {h_r.dst_addr, h_r.src_addr};
      rw_p[rev_slot] <= {h_r.dst_port, h_r.src_port};
      if (rev_slot != f1_idx) begin
        key_a[f1_idx] <= {h_r.src_addr, h_r.dst_addr};
        key_p[f1_idx] <= {h_r.src_port, h_r.dst_port};
        rw_a[f1_idx] <= {rsa_r, rda_r};
        rw_p[f1_idx] <= {rsp_r, rdp_r};
      end
    end
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= nfr_pkg::ST_IDLE;
      off_r <= '0;
      ov_r <= 1'b0;
      valid_r <= '0;
    end else begin
      st_r <= st_nxt;
      off_r <= off_nxt;
      ov_r <= ov_nxt;
      if (do_write) begin
        valid_r[rev_slot] <= 1'b1;
        if (rev_slot != f1_idx) valid_r[f1_idx] <= 1'b1;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_item = res_r;
  assign idle = (st_r == nfr_pkg::ST_IDLE);
endmodule
`default_nettype wire

### rtl/nat_flow_rewriter.sv
`default_nettype none
// NAT flow rewriter: classifies IPv4 headers and rewrites TCP/UDP 4-tuples
// through a flow table, inserting forward and reverse entries on a miss in pattern mode.
// Input: present in_item with start high; the item is taken when busy is low.
// Output: out_valid strobes for one cycle with out_item; the receiver cannot
// stall, so every result is delivered on its strobe cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index (register number) and
// cfg_data; write only while the block is idle. cfg_ready is always high.
// An item passes the front register and the queue; the engine pops it while
// idle and drops it at once if ineligible; else the match step leads to emit
// on a table hit, to a drop result on a miss in drop mode, or through reverse
// match and decide to emit for a new flow or to a full result when the table is full.
// A two-entry queue parts the classifier from the table engine, which handles
// one item at a time; new items enter the front and the queue while the engine
// is busy, until the queue is full.
// Reset (rst_n low, synchronous) clears all valid bits, the variation offset,
// queue pointers, configuration and control state; no clearing pass is needed.
module nat_flow_rewriter #(
  parameter int unsigned TABLE_ENTRIES = nfr_pkg::TableEntriesDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire nfr_pkg::in_item_t             in_item,
  output logic                               out_valid,
  output nfr_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [nfr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [nfr_pkg::CfgDataW-1:0]  cfg_data
);
  nfr_pkg::cfg_t cfg_r;
  nfr_pkg::cls_item_t cls_r, q_rd;
  logic q_push, q_full, q_pop, q_empty;
  logic stage_v_r, take, back_idle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nfr_pkg::REG_INPUT_MODE:   cfg_r.input_mode <= cfg_data[0];
        nfr_pkg::REG_PAT_SRC_ADDR: cfg_r.pat_src_addr <= cfg_data;
        nfr_pkg::REG_PAT_SRC_PORT: cfg_r.pat_src_port <= cfg_data[15:0];
        nfr_pkg::REG_PAT_DST_ADDR: cfg_r.pat_dst_addr <= cfg_data;
        nfr_pkg::REG_PAT_DST_PORT: cfg_r.pat_dst_port <= cfg_data[15:0];
        nfr_pkg::REG_VAR_TOP:      cfg_r.var_top <= cfg_data;
        nfr_pkg::REG_VAR_TARGET:   cfg_r.var_target <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // hold the front stage until the queue has room
  assign q_push = stage_v_r && !q_full;
  assign busy = stage_v_r && q_full;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (take) begin
      stage_v_r <= 1'b1;
    end else if (q_push) begin
      stage_v_r <= 1'b0;
    end
  end

  nfr_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .hdr   (in_item),
    .cls_r (cls_r)
  );

  nfr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (cls_r),
    .pop   (q_pop),
    .rdata (q_rd),
    .full  (q_full),
    .empty (q_empty)
  );

  nfr_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .idle      (back_idle)
  );

`include "nat_flow_rewriter_assert.svh"

  `NFR_ASSERT_IMPL(a_busy_needs_stage, busy, stage_v_r)
  `NFR_ASSERT_IMPL(a_drop_zero, out_valid && out_item.verdict == nfr_pkg::VERDICT_DROP,
      out_item.was_match == 1'b0)
  `NFR_ASSERT_NEXT(a_pop_leaves_idle_or_emits, q_pop && !q_rd.eligible, out_valid)
  `NFR_ASSERT_IMPL(a_pop_only_idle, q_pop, back_idle)

endmodule
`default_nettype wire
